[src/kfs_pkg.sv]
// kfs_pkg: shared widths, register indexes and fixed-point helpers
// for the kalman filter step block; no dependencies
`timescale 1ns / 1ps

package kfs_pkg;

  localparam int ACC_W      = 72;
  localparam int OPA_W      = 38;
  localparam int OPB_W      = 32;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int DIV_DEND_W = 56;
  localparam int DIV_SOR_W  = 39;
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PNOISE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MNOISE = 3'd4;

  localparam logic [63:0] TRANS_RST  = 64'h1000_0000_0000_1000;
  localparam logic [31:0] CTRL_RST   = 32'h0000_0000;
  localparam logic [31:0] OBS_RST    = 32'h1000_1000;
  localparam logic [63:0] PNOISE_RST = 64'h5000_0000_0000_5000;
  localparam logic [14:0] MNOISE_RST = 15'h5000;
  localparam logic [31:0] COV_DIAG_RST = 32'd168;

  typedef struct packed {
    logic                  start;
    logic [DIV_DEND_W-1:0] dividend;
    logic [DIV_SOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_DEND_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [OPA_W-1:0] ext_a32(input logic [31:0] v);
    return $signed({{(OPA_W-32){v[31]}}, v});
  endfunction

  function automatic logic signed [OPB_W-1:0] ext_b16(input logic [15:0] v);
    return $signed({{(OPB_W-16){v[15]}}, v});
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_acc32(input logic [31:0] v);
    return $signed({{(ACC_W-32){v[31]}}, v});
  endfunction

  // q4.12 entry scaled up to q8.24
  function automatic logic signed [ACC_W-1:0] q12_to_acc(input logic [15:0] v);
    return $signed({{(ACC_W-28){v[15]}}, v, 12'd0});
  endfunction

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return !((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]));
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (ovf32(v)) begin
      return v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

endpackage

[src/kfs_div.sv]
// kfs_div: restoring unsigned divider, one quotient bit per cycle
// depends on kfs_pkg
`timescale 1ns / 1ps

module kfs_div (
  input  logic              clk,
  input  logic              rst,
  input  kfs_pkg::div_req_t req,
  output kfs_pkg::div_rsp_t rsp
);

  logic                            run;
  logic [kfs_pkg::DIV_CNT_W-1:0]   cnt;
  logic [kfs_pkg::DIV_DEND_W-1:0]  work;
  logic [kfs_pkg::DIV_SOR_W-1:0]   divisor;
  logic [kfs_pkg::DIV_SOR_W-1:0]   rem;
  logic                            done;
  logic [kfs_pkg::DIV_SOR_W:0]     trial;
  logic                            fits;

  assign trial = {rem, work[kfs_pkg::DIV_DEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run     <= 1'b1;
        cnt     <= kfs_pkg::DIV_CNT_W'(kfs_pkg::DIV_DEND_W);
        work    <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (run) begin
        rem  <= fits ? kfs_pkg::DIV_SOR_W'(trial - {1'b0, divisor})
                     : trial[kfs_pkg::DIV_SOR_W-1:0];
        work <= {work[kfs_pkg::DIV_DEND_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == kfs_pkg::DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;

endmodule

[src/kalman_filter_step.sv]
// kalman_filter_step: two-state kalman predict/correct step on one shared
// multiply-accumulate unit and a bit-serial divider; depends on kfs_pkg, kfs_div
// per item: 42 multiply-accumulates and two gain divisions; only 32
// multiply-accumulates and no division when the innovation variance is not
// positive. one item at a time; in_stall is high from acceptance until done.
// reset: synchronous, loads default matrices and the default covariance
`timescale 1ns / 1ps

module kalman_filter_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    prior_est0,
  input  logic [31:0]                    prior_est1,
  input  logic [31:0]                    meas0,
  input  logic [31:0]                    meas1,
  input  logic [31:0]                    ctrl_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    post_est0,
  output logic [31:0]                    post_est1,
  output logic                           sat_flag
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIVS = 3'd4;
  localparam logic [2:0] ST_DIVW = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [5:0] STEP_S   = 6'd31;
  localparam logic [5:0] STEP_INN = 6'd32;
  localparam logic [5:0] STEP_DIV = 6'd35;
  localparam logic [5:0] STEP_FIN = 6'd36;
  localparam logic [5:0] STEP_END = 6'd41;

  logic [63:0] trans_matrix;
  logic [31:0] ctrl_matrix;
  logic [31:0] obs_matrix;
  logic [63:0] proc_noise_cov;
  logic [14:0] meas_noise_var;
  logic [31:0] err_cov [4];

  logic [2:0]  state;
  logic [5:0]  step;
  logic        div_idx;
  logic        flag;

  logic [31:0] x0, x1, m0, m1, u;
  logic [31:0] xp0, xp1, v0, v1, w0, w1, kg0, kg1, inn, xn0, xn1;
  logic [kfs_pkg::OPA_W-1:0] t [4];
  logic [31:0] pp [4];
  logic signed [39:0] s;

  logic signed [kfs_pkg::OPA_W-1:0]  opa;
  logic signed [kfs_pkg::OPB_W-1:0]  opb;
  logic                              first, neg;
  logic signed [kfs_pkg::PROD_W-1:0] prod;
  logic signed [kfs_pkg::ACC_W-1:0]  acc, acc_next, r12, r24, prod_ext, acc_base;

  logic [15:0] a0, a1, a2, a3, b0, b1, h0, h1;

  kfs_pkg::div_req_t div_req;
  kfs_pkg::div_rsp_t div_rsp;
  logic [31:0] div_v, div_mag, kg_val;
  logic        kg_ovf;
  logic [kfs_pkg::DIV_DEND_W-1:0] q;

  assign a0 = trans_matrix[15:0];
  assign a1 = trans_matrix[31:16];
  assign a2 = trans_matrix[47:32];
  assign a3 = trans_matrix[63:48];
  assign b0 = ctrl_matrix[15:0];
  assign b1 = ctrl_matrix[31:16];
  assign h0 = obs_matrix[15:0];
  assign h1 = obs_matrix[31:16];

  assign in_stall = (state != ST_IDLE);

  // operand schedule of the shared multiplier
  always_comb begin
    opa   = '0;
    opb   = '0;
    first = 1'b0;
    neg   = 1'b0;
    case (step)
      6'd0:  begin opa = kfs_pkg::ext_a32(x0);  opb = kfs_pkg::ext_b16(a0); first = 1'b1; end
      6'd1:  begin opa = kfs_pkg::ext_a32(x1);  opb = kfs_pkg::ext_b16(a1); end
      6'd2:  begin opa = kfs_pkg::ext_a32(u);   opb = kfs_pkg::ext_b16(b0); end
      6'd3:  begin opa = kfs_pkg::ext_a32(x0);  opb = kfs_pkg::ext_b16(a2); first = 1'b1; end
      6'd4:  begin opa = kfs_pkg::ext_a32(x1);  opb = kfs_pkg::ext_b16(a3); end
      6'd5:  begin opa = kfs_pkg::ext_a32(u);   opb = kfs_pkg::ext_b16(b1); end
      6'd6:  begin opa = kfs_pkg::ext_a32(err_cov[0]); opb = kfs_pkg::ext_b16(a0); first = 1'b1; end
      6'd7:  begin opa = kfs_pkg::ext_a32(err_cov[2]); opb = kfs_pkg::ext_b16(a1); end
      6'd8:  begin opa = kfs_pkg::ext_a32(err_cov[1]); opb = kfs_pkg::ext_b16(a0); first = 1'b1; end
      6'd9:  begin opa = kfs_pkg::ext_a32(err_cov[3]); opb = kfs_pkg::ext_b16(a1); end
      6'd10: begin opa = kfs_pkg::ext_a32(err_cov[0]); opb = kfs_pkg::ext_b16(a2); first = 1'b1; end
      6'd11: begin opa = kfs_pkg::ext_a32(err_cov[2]); opb = kfs_pkg::ext_b16(a3); end
      6'd12: begin opa = kfs_pkg::ext_a32(err_cov[1]); opb = kfs_pkg::ext_b16(a2); first = 1'b1; end
      6'd13: begin opa = kfs_pkg::ext_a32(err_cov[3]); opb = kfs_pkg::ext_b16(a3); end
      6'd14: begin opa = $signed(t[0]); opb = kfs_pkg::ext_b16(a0); first = 1'b1; end
      6'd15: begin opa = $signed(t[1]); opb = kfs_pkg::ext_b16(a1); end
      6'd16: begin opa = $signed(t[0]); opb = kfs_pkg::ext_b16(a2); first = 1'b1; end
      6'd17: begin opa = $signed(t[1]); opb = kfs_pkg::ext_b16(a3); end
      6'd18: begin opa = $signed(t[2]); opb = kfs_pkg::ext_b16(a0); first = 1'b1; end
      6'd19: begin opa = $signed(t[3]); opb = kfs_pkg::ext_b16(a1); end
      6'd20: begin opa = $signed(t[2]); opb = kfs_pkg::ext_b16(a2); first = 1'b1; end
      6'd21: begin opa = $signed(t[3]); opb = kfs_pkg::ext_b16(a3); end
      6'd22: begin opa = kfs_pkg::ext_a32(pp[0]); opb = kfs_pkg::ext_b16(h0); first = 1'b1; end
      6'd23: begin opa = kfs_pkg::ext_a32(pp[1]); opb = kfs_pkg::ext_b16(h1); end
      6'd24: begin opa = kfs_pkg::ext_a32(pp[2]); opb = kfs_pkg::ext_b16(h0); first = 1'b1; end
      6'd25: begin opa = kfs_pkg::ext_a32(pp[3]); opb = kfs_pkg::ext_b16(h1); end
      6'd26: begin opa = kfs_pkg::ext_a32(pp[0]); opb = kfs_pkg::ext_b16(h0); first = 1'b1; end
      6'd27: begin opa = kfs_pkg::ext_a32(pp[2]); opb = kfs_pkg::ext_b16(h1); end
      6'd28: begin opa = kfs_pkg::ext_a32(pp[1]); opb = kfs_pkg::ext_b16(h0); first = 1'b1; end
      6'd29: begin opa = kfs_pkg::ext_a32(pp[3]); opb = kfs_pkg::ext_b16(h1); end
      6'd30: begin opa = kfs_pkg::ext_a32(v0);  opb = kfs_pkg::ext_b16(h0); first = 1'b1; end
      6'd31: begin opa = kfs_pkg::ext_a32(v1);  opb = kfs_pkg::ext_b16(h1); end
      6'd32: begin opa = kfs_pkg::ext_a32(m0);  opb = kfs_pkg::ext_b16(h0); first = 1'b1; end
      6'd33: begin opa = kfs_pkg::ext_a32(xp0); opb = kfs_pkg::ext_b16(h0); neg = 1'b1; end
      6'd34: begin opa = kfs_pkg::ext_a32(m1);  opb = kfs_pkg::ext_b16(h1); end
      6'd35: begin opa = kfs_pkg::ext_a32(xp1); opb = kfs_pkg::ext_b16(h1); neg = 1'b1; end
      6'd36: begin opa = kfs_pkg::ext_a32(kg0); opb = $signed(inn); first = 1'b1; end
      6'd37: begin opa = kfs_pkg::ext_a32(kg1); opb = $signed(inn); first = 1'b1; end
      6'd38: begin opa = kfs_pkg::ext_a32(kg0); opb = $signed(w0);  first = 1'b1; end
      6'd39: begin opa = kfs_pkg::ext_a32(kg0); opb = $signed(w1);  first = 1'b1; end
      6'd40: begin opa = kfs_pkg::ext_a32(kg1); opb = $signed(w0);  first = 1'b1; end
      6'd41: begin opa = kfs_pkg::ext_a32(kg1); opb = $signed(w1);  first = 1'b1; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    prod_ext = $signed({{(kfs_pkg::ACC_W-kfs_pkg::PROD_W){prod[kfs_pkg::PROD_W-1]}}, prod});
    acc_base = first ? '0 : acc;
    acc_next = neg ? (acc_base - prod_ext) : (acc_base + prod_ext);
    r12      = (acc_next + kfs_pkg::ACC_W'(2048)) >>> 12;
    r24      = (acc_next + $signed(kfs_pkg::ACC_W'(24'h80_0000))) >>> 24;
  end

  // gain division on magnitudes, sign restored afterwards
  always_comb begin
    div_v   = div_idx ? v1 : v0;
    div_mag = div_v[31] ? (~div_v + 32'd1) : div_v;
    div_req.start    = (state == ST_DIVS);
    div_req.dividend = {div_mag, 24'd0};
    div_req.divisor  = s[kfs_pkg::DIV_SOR_W-1:0];
    q = div_rsp.quot;
    if (div_v[31]) begin
      kg_ovf = (|q[kfs_pkg::DIV_DEND_W-1:32]) || (q[31] && (|q[30:0]));
      kg_val = kg_ovf ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      kg_ovf = |q[kfs_pkg::DIV_DEND_W-1:31];
      kg_val = kg_ovf ? 32'h7fff_ffff : q[31:0];
    end
  end

  kfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_matrix   <= kfs_pkg::TRANS_RST;
      ctrl_matrix    <= kfs_pkg::CTRL_RST;
      obs_matrix     <= kfs_pkg::OBS_RST;
      proc_noise_cov <= kfs_pkg::PNOISE_RST;
      meas_noise_var <= kfs_pkg::MNOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kfs_pkg::CFG_TRANS:  trans_matrix   <= cfg_data;
        kfs_pkg::CFG_CTRL:   ctrl_matrix    <= cfg_data[31:0];
        kfs_pkg::CFG_OBS:    obs_matrix     <= cfg_data[31:0];
        kfs_pkg::CFG_PNOISE: proc_noise_cov <= cfg_data;
        kfs_pkg::CFG_MNOISE: meas_noise_var <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      div_idx    <= 1'b0;
      out_valid  <= 1'b0;
      err_cov[0] <= kfs_pkg::COV_DIAG_RST;
      err_cov[1] <= '0;
      err_cov[2] <= '0;
      err_cov[3] <= kfs_pkg::COV_DIAG_RST;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x0    <= prior_est0;
            x1    <= prior_est1;
            m0    <= meas0;
            m1    <= meas1;
            u     <= ctrl_in;
            flag  <= 1'b0;
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= opa * opb;
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc_next;
          case (step)
            6'd2:  begin xp0 <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd5:  begin xp1 <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd7:  t[0] <= r12[kfs_pkg::OPA_W-1:0];
            6'd9:  t[1] <= r12[kfs_pkg::OPA_W-1:0];
            6'd11: t[2] <= r12[kfs_pkg::OPA_W-1:0];
            6'd13: t[3] <= r12[kfs_pkg::OPA_W-1:0];
            6'd15: begin
              pp[0] <= kfs_pkg::sat32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[15:0]));
              flag  <= flag | kfs_pkg::ovf32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[15:0]));
            end
            6'd17: begin
              pp[1] <= kfs_pkg::sat32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[31:16]));
              flag  <= flag | kfs_pkg::ovf32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[31:16]));
            end
            6'd19: begin
              pp[2] <= kfs_pkg::sat32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[47:32]));
              flag  <= flag | kfs_pkg::ovf32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[47:32]));
            end
            6'd21: begin
              pp[3] <= kfs_pkg::sat32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[63:48]));
              flag  <= flag | kfs_pkg::ovf32(r12 + kfs_pkg::q12_to_acc(proc_noise_cov[63:48]));
            end
            6'd23: begin v0 <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd25: begin v1 <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd27: begin w0 <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd29: begin w1 <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd31: s <= r12[39:0] + $signed({13'd0, meas_noise_var, 12'd0});
            6'd35: begin inn <= kfs_pkg::sat32(r12); flag <= flag | kfs_pkg::ovf32(r12); end
            6'd36: begin
              xn0  <= kfs_pkg::sat32(kfs_pkg::ext_acc32(xp0) + r24);
              flag <= flag | kfs_pkg::ovf32(kfs_pkg::ext_acc32(xp0) + r24);
            end
            6'd37: begin
              xn1  <= kfs_pkg::sat32(kfs_pkg::ext_acc32(xp1) + r24);
              flag <= flag | kfs_pkg::ovf32(kfs_pkg::ext_acc32(xp1) + r24);
            end
            6'd38: begin
              err_cov[0] <= kfs_pkg::sat32(kfs_pkg::ext_acc32(pp[0]) - r24);
              flag       <= flag | kfs_pkg::ovf32(kfs_pkg::ext_acc32(pp[0]) - r24);
            end
            6'd39: begin
              err_cov[1] <= kfs_pkg::sat32(kfs_pkg::ext_acc32(pp[1]) - r24);
              flag       <= flag | kfs_pkg::ovf32(kfs_pkg::ext_acc32(pp[1]) - r24);
            end
            6'd40: begin
              err_cov[2] <= kfs_pkg::sat32(kfs_pkg::ext_acc32(pp[2]) - r24);
              flag       <= flag | kfs_pkg::ovf32(kfs_pkg::ext_acc32(pp[2]) - r24);
            end
            6'd41: begin
              err_cov[3] <= kfs_pkg::sat32(kfs_pkg::ext_acc32(pp[3]) - r24);
              flag       <= flag | kfs_pkg::ovf32(kfs_pkg::ext_acc32(pp[3]) - r24);
            end
            default: ;
          endcase
          if (step == STEP_S) begin
            state <= ST_CHK;
          end else if (step == STEP_DIV) begin
            div_idx <= 1'b0;
            state   <= ST_DIVS;
          end else if (step == STEP_END) begin
            state <= ST_DONE;
          end else begin
            step  <= step + 6'd1;
            state <= ST_MUL;
          end
        end
        ST_CHK: begin
          if (s <= 40'sd0) begin
            // no correction: keep the prediction
            xn0        <= xp0;
            xn1        <= xp1;
            err_cov[0] <= pp[0];
            err_cov[1] <= pp[1];
            err_cov[2] <= pp[2];
            err_cov[3] <= pp[3];
            flag       <= 1'b1;
            state      <= ST_DONE;
          end else begin
            step  <= STEP_INN;
            state <= ST_MUL;
          end
        end
        ST_DIVS: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            flag <= flag | kg_ovf;
            if (!div_idx) begin
              kg0     <= kg_val;
              div_idx <= 1'b1;
              state   <= ST_DIVS;
            end else begin
              kg1   <= kg_val;
              step  <= STEP_FIN;
              state <= ST_MUL;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            post_est0 <= xn0;
            post_est1 <= xn1;
            sat_flag  <= flag;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL && step == 6'd0))
    else $error("accepted item did not start the sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the done state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIVW))
    else $error("divider finished while not awaited");

  a_div_positive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVS) |-> (s > 40'sd0))
    else $error("division started with a non-positive divisor");

endmodule
